// ===== hw/rtl/bmsi_pkg.sv =====
`default_nettype none

package bmsi_pkg;

    localparam int A12_FILTER_CYCLES = 16;
    localparam logic [4:0] A12_HOLDOFF_LOAD = 5'(A12_FILTER_CYCLES & 'h1F);
    localparam logic [1:0] FIRE_DELAY_LOAD = 2'd2;

    // write decode: cpu address masked to the port select bits
    localparam logic [15:0] ADDR_MASK        = 16'hF001;
    localparam logic [15:0] PORT_BANK_SELECT = 16'h8000;
    localparam logic [15:0] PORT_BANK_DATA   = 16'h8001;
    localparam logic [15:0] PORT_MIRROR      = 16'hA000;
    localparam logic [15:0] PORT_IRQ_LATCH   = 16'hC000;
    localparam logic [15:0] PORT_IRQ_RELOAD  = 16'hC001;
    localparam logic [15:0] PORT_IRQ_OFF     = 16'hE000;
    localparam logic [15:0] PORT_IRQ_ON      = 16'hE001;

    // bank index codes beyond the first six chr registers
    localparam logic [3:0] REG_PRG0 = 4'h6;
    localparam logic [3:0] REG_PRG1 = 4'h7;
    localparam logic [3:0] REG_CHR6 = 4'h8;
    localparam logic [3:0] REG_CHR7 = 4'h9;
    localparam logic [3:0] REG_PRG2 = 4'hF;

    localparam logic [7:0] PRG_LAST_BANK = 8'hFF;

    typedef struct packed {
        logic        opcode;
        logic [15:0] cpu_address;
        logic [7:0]  write_data;
        logic        a12_level;
        logic [13:0] ppu_address;
    } bmsi_item_t;

    typedef struct packed {
        logic [7:0]       bank_select;
        logic [2:0][7:0]  prg_regs;
        logic [7:0][7:0]  chr_regs;
        logic             mirror_select;
    } bmsi_banks_t;

    typedef struct packed {
        logic       nametable_page;
        logic [7:0] chr_bank;
        logic [7:0] prg_bank;
        logic       prg_hit;
    } bmsi_xlate_t;

endpackage

`default_nettype wire

// ===== hw/rtl/bmsi_regs.sv =====
`default_nettype none

module bmsi_regs
    import bmsi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire bmsi_item_t  item,
    output bmsi_banks_t      banks_next
);

    logic [7:0]      bank_select_reg, bank_select_next;
    logic [2:0][7:0] prg_reg, prg_next;
    logic [7:0][7:0] chr_reg, chr_next;
    logic            mirror_reg, mirror_next;
    logic [15:0]     port;
    logic [3:0]      idx;

    assign port = item.cpu_address & ADDR_MASK;
    assign idx  = bank_select_reg[3:0];

    always_comb begin
        bank_select_next = bank_select_reg;
        prg_next         = prg_reg;
        chr_next         = chr_reg;
        mirror_next      = mirror_reg;
        if (item.opcode) begin
            case (port)
                PORT_BANK_SELECT: bank_select_next = item.write_data;
                PORT_BANK_DATA: begin
                    case (idx) inside
                        [4'h0:4'h5]:        chr_next[idx[2:0]] = item.write_data;
                        REG_PRG0, REG_PRG1: prg_next[{1'b0, idx[0]}] = item.write_data;
                        REG_CHR6, REG_CHR7: chr_next[{2'b11, idx[0]}] = item.write_data;
                        REG_PRG2:           prg_next[2] = item.write_data;
                        default: ;
                    endcase
                end
                PORT_MIRROR: mirror_next = item.write_data[0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            bank_select_reg <= '0;
            prg_reg[0]      <= 8'h00;
            prg_reg[1]      <= 8'h01;
            prg_reg[2]      <= 8'hFE;
            for (int i = 0; i < 8; i++) begin
                chr_reg[i] <= 8'(i);
            end
            mirror_reg      <= 1'b0;
        end else if (step) begin
            bank_select_reg <= bank_select_next;
            prg_reg         <= prg_next;
            chr_reg         <= chr_next;
            mirror_reg      <= mirror_next;
        end
    end

    assign banks_next.bank_select   = bank_select_next;
    assign banks_next.prg_regs      = prg_next;
    assign banks_next.chr_regs      = chr_next;
    assign banks_next.mirror_select = mirror_next;

endmodule

`default_nettype wire

// ===== hw/rtl/bmsi_irq.sv =====
`default_nettype none

module bmsi_irq
    import bmsi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        step,
    input  wire bmsi_item_t  item,
    output logic             irq_next
);

    logic [7:0] latch_reg, latch_next;
    logic [7:0] counter_reg, counter_next;
    logic       reload_reg, reload_next;
    logic       extra_reg, extra_next;
    logic       source_reg, source_next;
    logic       enable_reg, enable_next;
    logic [1:0] presc_reg, presc_next;
    logic [1:0] delay_reg, delay_next;
    logic [4:0] holdoff_reg, holdoff_next;
    logic       pending_reg;

    logic [15:0] port;
    logic [7:0]  latch_w, counter_w, reload_value, counter_clocked;
    logic        reload_w, source_w, enable_w;
    logic [1:0]  presc_w;
    logic        pend_t, clk_en, fire;

    assign port = item.cpu_address & ADDR_MASK;

    always_comb begin
        latch_w    = latch_reg;
        counter_w  = counter_reg;
        reload_w   = reload_reg;
        extra_next = extra_reg;
        source_w   = source_reg;
        enable_w   = enable_reg;
        presc_w    = presc_reg;
        if (item.opcode) begin
            case (port)
                PORT_IRQ_LATCH: latch_w = item.write_data;
                PORT_IRQ_RELOAD: begin
                    source_w   = item.write_data[0];
                    presc_w    = 2'd0;
                    counter_w  = 8'd0;
                    reload_w   = 1'b1;
                    extra_next = (holdoff_reg == 5'd0);
                end
                PORT_IRQ_OFF: enable_w = 1'b0;
                PORT_IRQ_ON:  enable_w = 1'b1;
                default: ;
            endcase
        end
    end

    always_comb begin
        // fire delay runs down before any counter clock of this cycle
        pend_t     = pending_reg | (delay_reg == 2'd1);
        delay_next = (delay_reg != 2'd0) ? delay_reg - 2'd1 : delay_reg;
        presc_next = presc_w + 2'd1;
        clk_en     = ((presc_next == 2'd0) && source_w)
                   || (item.a12_level && (holdoff_reg == 5'd0) && !source_w);

        reload_value    = latch_w + {7'd0, reload_w & extra_next};
        counter_clocked = counter_w - 8'd1;
        if (counter_w == 8'd0) begin
            fire = (reload_value == 8'd0) && reload_w && enable_w;
        end else begin
            fire = (counter_clocked == 8'd0) && enable_w;
        end

        counter_next = counter_w;
        reload_next  = reload_w;
        if (clk_en) begin
            counter_next = (counter_w == 8'd0) ? reload_value : counter_clocked;
            reload_next  = 1'b0;
            if (fire) begin
                delay_next = FIRE_DELAY_LOAD;
            end
        end

        if (item.a12_level) begin
            holdoff_next = A12_HOLDOFF_LOAD;
        end else if (holdoff_reg != 5'd0) begin
            holdoff_next = holdoff_reg - 5'd1;
        end else begin
            holdoff_next = holdoff_reg;
        end

        latch_next  = latch_w;
        source_next = source_w;
        enable_next = enable_w;
        irq_next    = enable_w & pend_t;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            latch_reg   <= '0;
            counter_reg <= '0;
            reload_reg  <= 1'b0;
            extra_reg   <= 1'b0;
            source_reg  <= 1'b0;
            enable_reg  <= 1'b0;
            presc_reg   <= '0;
            delay_reg   <= '0;
            holdoff_reg <= '0;
            pending_reg <= 1'b0;
        end else if (step) begin
            latch_reg   <= latch_next;
            counter_reg <= counter_next;
            reload_reg  <= reload_next;
            extra_reg   <= extra_next;
            source_reg  <= source_next;
            enable_reg  <= enable_next;
            presc_reg   <= presc_next;
            delay_reg   <= delay_next;
            holdoff_reg <= holdoff_next;
            pending_reg <= irq_next;
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bmsi_xlate.sv =====
`default_nettype none

module bmsi_xlate
    import bmsi_pkg::*;
(
    input  wire bmsi_banks_t  banks,
    input  wire logic         nametable_from_chr,
    input  wire logic [15:0]  cpu_address,
    input  wire logic [13:0]  ppu_address,
    output bmsi_xlate_t       xlate
);

    localparam logic [3:0][2:0] ONE_K_MAP = {3'd7, 3'd1, 3'd6, 3'd0};

    logic       prg_swap;
    logic [2:0] slot;
    logic [7:0] slot_bank;

    always_comb begin
        prg_swap = banks.bank_select[6];
        xlate.prg_hit  = cpu_address[15];
        xlate.prg_bank = 8'd0;
        if (cpu_address[15]) begin
            case (cpu_address[14:13])
                2'd0:    xlate.prg_bank = prg_swap ? banks.prg_regs[2] : banks.prg_regs[0];
                2'd1:    xlate.prg_bank = prg_swap ? banks.prg_regs[0] : banks.prg_regs[1];
                2'd2:    xlate.prg_bank = prg_swap ? banks.prg_regs[1] : banks.prg_regs[2];
                default: xlate.prg_bank = PRG_LAST_BANK;
            endcase
        end
    end

    always_comb begin
        // bank select bit 7 swaps the two pattern table halves
        slot = {ppu_address[12] ^ banks.bank_select[7], ppu_address[11:10]};
        if (slot[2]) begin
            slot_bank = banks.chr_regs[slot - 3'd2];
        end else if (banks.bank_select[5]) begin
            slot_bank = banks.chr_regs[ONE_K_MAP[slot[1:0]]];
        end else begin
            slot_bank = {banks.chr_regs[{2'b00, slot[1]}][7:1], slot[0]};
        end

        xlate.chr_bank       = 8'd0;
        xlate.nametable_page = 1'b0;
        if (!ppu_address[13]) begin
            xlate.chr_bank = slot_bank;
        end else if (nametable_from_chr) begin
            xlate.nametable_page = slot_bank[7];
        end else if (banks.mirror_select) begin
            xlate.nametable_page = ppu_address[11];
        end else begin
            xlate.nametable_page = ppu_address[10];
        end
    end

endmodule

`default_nettype wire

// ===== hw/rtl/bank_mapper_with_scanline_irq_unit.sv =====
// channel   dir  tdata fields (low bit up)                              tuser
// s_        in   cpu_address[15:0] write_data[23:16] a12_level[24]      opcode
//                ppu_address[38:25], bit 39 zero
// m_        out  irq_line[0] prg_hit[1] prg_bank[9:2] chr_bank[17:10]   -
//                nametable_page[18], bits 23:19 zero
// cfg       in   cfg_wr_data = nametable_from_chr, written when cfg_wr_en
//
// one item per clock sustained while m_tready is high; an accepted item waits in the
// input register and then moves into the result register, which drives m_ and m_tvalid.
// mapper and irq state advance when an item moves from the input register into the
// result register. aresetn (synchronous) empties both registers and loads reset banks.
// a stall on m_tready holds the result and the input register; s_tready drops only
// when both are full and m_tready is low.
`default_nettype none

module bank_mapper_with_scanline_irq_unit
    import bmsi_pkg::*;
(
    input  wire logic        aclk,
    input  wire logic        aresetn,

    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [39:0] s_tdata,   // cpu_address, write_data, a12_level, ppu_address
    input  wire logic        s_tuser,   // opcode

    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [23:0]      m_tdata,   // irq_line, prg_hit, prg_bank, chr_bank, nametable_page

    input  wire logic        cfg_wr_en,
    input  wire logic        cfg_wr_data
);

    bmsi_item_t  item_reg;
    logic        in_valid_reg;
    logic [18:0] result_reg;
    logic        out_valid_reg;
    logic        nt_from_chr_reg;
    logic        step;
    logic        irq_next;
    bmsi_banks_t banks_next;
    bmsi_xlate_t xlate;

    assign step     = in_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || step;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg    <= 1'b0;
            out_valid_reg   <= 1'b0;
            nt_from_chr_reg <= 1'b0;
        end else begin
            if (s_tready) begin
                in_valid_reg <= s_tvalid;
            end
            if (step) begin
                out_valid_reg <= 1'b1;
            end else if (m_tready) begin
                out_valid_reg <= 1'b0;
            end
            if (cfg_wr_en) begin
                nt_from_chr_reg <= cfg_wr_data;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (s_tready && s_tvalid) begin
            item_reg.opcode      <= s_tuser;
            item_reg.cpu_address <= s_tdata[15:0];
            item_reg.write_data  <= s_tdata[23:16];
            item_reg.a12_level   <= s_tdata[24];
            item_reg.ppu_address <= s_tdata[38:25];
        end
        if (step) begin
            result_reg <= {xlate, irq_next};
        end
    end

    bmsi_regs u_regs (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .step       (step),
        .item       (item_reg),
        .banks_next (banks_next)
    );

    bmsi_irq u_irq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .step     (step),
        .item     (item_reg),
        .irq_next (irq_next)
    );

    bmsi_xlate u_xlate (
        .banks              (banks_next),
        .nametable_from_chr (nt_from_chr_reg),
        .cpu_address        (item_reg.cpu_address),
        .ppu_address        (item_reg.ppu_address),
        .xlate              (xlate)
    );

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, result_reg};

endmodule

`default_nettype wire

// ===== hw/rtl/bmsi_checker.sv =====
`default_nettype none

module bmsi_checker (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    input  wire logic        m_tvalid,
    input  wire logic        m_tready,
    input  wire logic [23:0] m_tdata
);

    // nothing comes out the cycle after reset
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> !m_tvalid)
        else $error("result valid right after reset");

    // prg bank is zero whenever the cpu address misses the prg window
    a_prg_miss_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[1] |-> m_tdata[9:2] == 8'd0)
        else $error("prg bank set on a miss");

    // a nonzero chr bank means a pattern fetch, so no nametable page
    a_chr_excludes_nt: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[17:10] != 8'd0 |-> !m_tdata[18])
        else $error("chr bank and nametable page both set");

    a_stall_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result item changed");

endmodule

bind bank_mapper_with_scanline_irq_unit bmsi_checker u_bmsi_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire

// ===== tb/sv/bank_mapper_with_scanline_irq_unit_test.sv =====
`default_nettype none

module bank_mapper_with_scanline_irq_unit_test;
    import bmsi_pkg::*;

    localparam int CYCLE_LIMIT = 300000;
    localparam int PHASE_ITEMS = 250;
    localparam int HOLD_AT = 400;
    localparam int HOLD_CYCLES = 250;
    localparam logic OP_CYCLE = 1'b0;
    localparam logic OP_WRITE = 1'b1;
    localparam logic [3:0] LAST_DIRECT_CHR = 4'h5;

    typedef struct packed {
        bmsi_xlate_t xl;
        logic        irq;
    } cycle_out_t;

    typedef enum logic [1:0] {SINK_OPEN, SINK_CHOPPY, SINK_SLOW} sink_mode_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata = '0;     // cpu_address, write_data, a12_level, ppu_address
    logic        s_tuser = 1'b0;   // opcode
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;          // irq_line, prg_hit, prg_bank, chr_bank, nametable_page
    logic        cfg_wr_en = 1'b0;
    logic        cfg_wr_data = 1'b0;

    bank_mapper_with_scanline_irq_unit dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data)
    );

    always #6 aclk = ~aclk;

    // mapper state as the testbench sees it
    logic [7:0] bank_ctl;
    logic [7:0] prg_set [3];
    logic [7:0] chr_set [8];
    logic       mirror_h;
    logic [7:0] irq_reload;
    logic [7:0] irq_count;
    logic       reload_armed;
    logic       reload_bonus;
    logic       count_cpu;
    logic       irq_on;
    logic [1:0] pre_div;
    logic [1:0] fire_wait;
    logic [4:0] a12_quiet;
    logic       irq_out;
    logic       nt_cfg;

    bmsi_item_t cycle_q [$];
    cycle_out_t expect_q [$];

    int unsigned items_in = 0;
    int unsigned mismatches = 0;
    int unsigned cycles = 0;
    int unsigned burst_left = 0;
    int unsigned gap_left = 0;
    int unsigned hold_left = 0;
    logic        hold_done = 1'b0;
    int unsigned sink_left = 0;
    sink_mode_t  sink_mode = SINK_OPEN;
    logic        a12_now = 1'b0;
    int unsigned a12_left = 0;

    function automatic void step_counter();
        if (irq_count == 8'd0) begin
            irq_count = irq_reload + (reload_armed ? 8'(reload_bonus) : 8'd0);
            if (irq_count == 8'd0 && reload_armed && irq_on)
                fire_wait = FIRE_DELAY_LOAD;
        end else begin
            irq_count = irq_count - 8'd1;
            if (irq_count == 8'd0 && irq_on)
                fire_wait = FIRE_DELAY_LOAD;
        end
        reload_armed = 1'b0;
    endfunction

    function automatic logic [7:0] chr_slot_bank(input logic [2:0] s, input logic two_k);
        if (s[2])
            return chr_set[s - 3'd2];
        if (!two_k) begin
            case (s[1:0])
                2'd0:    return chr_set[0];
                2'd1:    return chr_set[6];
                2'd2:    return chr_set[1];
                default: return chr_set[7];
            endcase
        end
        return {chr_set[{2'b00, s[1]}][7:1], s[0]};
    endfunction

    // one cpu cycle: register write, irq tick, then address translation
    function automatic void run_cycle(input bmsi_item_t it);
        logic [3:0] idx;
        logic [2:0] slot;
        logic       two_k;
        logic [7:0] nt_bank;
        cycle_out_t res;
        res = '0;
        if (it.opcode == OP_WRITE) begin
            case (it.cpu_address & ADDR_MASK)
                PORT_BANK_SELECT: bank_ctl = it.write_data;
                PORT_BANK_DATA: begin
                    idx = bank_ctl[3:0];
                    if (idx <= LAST_DIRECT_CHR)
                        chr_set[idx[2:0]] = it.write_data;
                    else if (idx == REG_PRG0 || idx == REG_PRG1)
                        prg_set[{1'b0, idx[0]}] = it.write_data;
                    else if (idx == REG_CHR6 || idx == REG_CHR7)
                        chr_set[3'(idx - 4'd2)] = it.write_data;
                    else if (idx == REG_PRG2)
                        prg_set[2] = it.write_data;
                end
                PORT_MIRROR:    mirror_h = it.write_data[0];
                PORT_IRQ_LATCH: irq_reload = it.write_data;
                PORT_IRQ_RELOAD: begin
                    count_cpu = it.write_data[0];
                    pre_div = 2'd0;
                    irq_count = 8'd0;
                    reload_armed = 1'b1;
                    reload_bonus = (a12_quiet == 5'd0);
                end
                PORT_IRQ_OFF: irq_on = 1'b0;
                PORT_IRQ_ON:  irq_on = 1'b1;
                default: ;
            endcase
        end

        if (fire_wait != 2'd0) begin
            fire_wait = fire_wait - 2'd1;
            if (fire_wait == 2'd0)
                irq_out = 1'b1;
        end
        pre_div = pre_div + 2'd1;
        if (pre_div == 2'd0 && count_cpu)
            step_counter();
        if (it.a12_level) begin
            if (a12_quiet == 5'd0 && !count_cpu)
                step_counter();
            a12_quiet = A12_HOLDOFF_LOAD;
        end else if (a12_quiet != 5'd0) begin
            a12_quiet = a12_quiet - 5'd1;
        end
        if (!irq_on)
            irq_out = 1'b0;

        two_k = !bank_ctl[5];
        res.irq = irq_out;
        if (it.cpu_address[15]) begin
            res.xl.prg_hit = 1'b1;
            case (it.cpu_address[14:13])
                2'd0:    res.xl.prg_bank = bank_ctl[6] ? prg_set[2] : prg_set[0];
                2'd1:    res.xl.prg_bank = bank_ctl[6] ? prg_set[0] : prg_set[1];
                2'd2:    res.xl.prg_bank = bank_ctl[6] ? prg_set[1] : prg_set[2];
                default: res.xl.prg_bank = PRG_LAST_BANK;
            endcase
        end
        slot = it.ppu_address[12:10] ^ {bank_ctl[7], 2'b00};
        if (!it.ppu_address[13]) begin
            res.xl.chr_bank = chr_slot_bank(slot, two_k);
        end else if (nt_cfg) begin
            nt_bank = chr_slot_bank(slot, two_k);
            res.xl.nametable_page = nt_bank[7];
        end else if (mirror_h) begin
            res.xl.nametable_page = it.ppu_address[11];
        end else begin
            res.xl.nametable_page = it.ppu_address[10];
        end
        expect_q.push_back(res);
    endfunction

    // a12 looks like scanline fetches: short high pulses, gaps above and below the filter
    function automatic bmsi_item_t random_cycle();
        bmsi_item_t it;
        int unsigned pick;
        logic [15:0] port;
        it.cpu_address = 16'($urandom());
        it.write_data = 8'($urandom());
        it.ppu_address = 14'($urandom());
        it.opcode = ($urandom_range(0, 99) < 30) ? OP_WRITE : OP_CYCLE;
        if (a12_left == 0) begin
            a12_now = ~a12_now;
            a12_left = a12_now ? $urandom_range(1, 4) : $urandom_range(1, 40);
        end
        a12_left = a12_left - 1;
        it.a12_level = a12_now;
        if (it.opcode == OP_WRITE) begin
            pick = $urandom_range(0, 99);
            if (pick < 18)      port = PORT_BANK_SELECT;
            else if (pick < 42) port = PORT_BANK_DATA;
            else if (pick < 52) port = PORT_MIRROR;
            else if (pick < 67) port = PORT_IRQ_LATCH;
            else if (pick < 76) port = PORT_IRQ_RELOAD;
            else if (pick < 81) port = PORT_IRQ_OFF;
            else if (pick < 93) port = PORT_IRQ_ON;
            else                port = 16'($urandom());
            it.cpu_address = port | (16'($urandom()) & ~ADDR_MASK);
            if (port == PORT_IRQ_LATCH && $urandom_range(0, 1) == 0)
                it.write_data = 8'($urandom_range(0, 6));
        end
        return it;
    endfunction

    task automatic add_cycle(input logic op, input logic [15:0] ca, input logic [7:0] wd,
                             input logic a12, input logic [13:0] pa);
        bmsi_item_t it;
        it.opcode = op;
        it.cpu_address = ca;
        it.write_data = wd;
        it.a12_level = a12;
        it.ppu_address = pa;
        cycle_q.push_back(it);
    endtask

    task automatic wait_drained();
        do @(posedge aclk);
        while (cycle_q.size() != 0 || s_tvalid || expect_q.size() != 0);
    endtask

    task automatic set_nametable_cfg(input logic v);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_wr_data <= v;
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        nt_cfg = v;
    endtask

    always @(posedge aclk) begin : source_drive
        logic offer;
        offer = 1'b0;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || s_tready) begin
            if (s_tvalid) begin
                run_cycle(cycle_q.pop_front());
                items_in <= items_in + 1;
            end
            if (gap_left != 0) begin
                gap_left = gap_left - 1;
            end else if (cycle_q.size() != 0) begin
                offer = 1'b1;
                if (burst_left <= 1) begin
                    burst_left = $urandom_range(1, 48);
                    gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
                end else begin
                    burst_left = burst_left - 1;
                end
            end
            s_tvalid <= offer;
            if (offer) begin
                s_tdata <= {1'b0, cycle_q[0].ppu_address, cycle_q[0].a12_level,
                            cycle_q[0].write_data, cycle_q[0].cpu_address};
                s_tuser <= cycle_q[0].opcode;
            end
        end
    end

    // one long receiver hold-off while items keep coming
    always @(posedge aclk) begin
        if (hold_left != 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && items_in == HOLD_AT) begin
            hold_left <= HOLD_CYCLES;
            hold_done <= 1'b1;
        end
    end

    always @(posedge aclk) begin : sink_drive
        logic rdy;
        if (sink_left == 0) begin
            sink_mode <= sink_mode_t'($urandom_range(0, 2));
            sink_left <= $urandom_range(8, 80);
        end else begin
            sink_left <= sink_left - 1;
        end
        case (sink_mode)
            SINK_OPEN:   rdy = 1'b1;
            SINK_CHOPPY: rdy = 1'($urandom_range(0, 1));
            default:     rdy = ($urandom_range(0, 3) == 0);
        endcase
        m_tready <= aresetn && rdy && hold_left == 0;
    end

    always @(posedge aclk) begin : result_check
        cycle_out_t want, got;
        if (aresetn && m_tvalid && m_tready) begin
            got = cycle_out_t'(m_tdata[18:0]);
            if (expect_q.size() == 0) begin
                mismatches = mismatches + 1;
                if (mismatches <= 10)
                    $display("unexpected result item %h", m_tdata);
            end else begin
                want = expect_q.pop_front();
                if (got.irq !== want.irq || got.xl.prg_hit !== want.xl.prg_hit ||
                    got.xl.prg_bank !== want.xl.prg_bank ||
                    got.xl.chr_bank !== want.xl.chr_bank ||
                    got.xl.nametable_page !== want.xl.nametable_page) begin
                    mismatches = mismatches + 1;
                    if (mismatches <= 10)
                        $display({"mismatch (exp/got): irq %b/%b hit %b/%b prg %h/%h ",
                                  "chr %h/%h nt %b/%b"},
                                 want.irq, got.irq, want.xl.prg_hit, got.xl.prg_hit,
                                 want.xl.prg_bank, got.xl.prg_bank,
                                 want.xl.chr_bank, got.xl.chr_bank,
                                 want.xl.nametable_page, got.xl.nametable_page);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT) begin
            $display("== FAIL ==");
            $finish;
        end
    end

    initial begin
        bank_ctl = 8'h00;
        prg_set[0] = 8'h00;
        prg_set[1] = 8'h01;
        prg_set[2] = 8'hFE;
        for (int i = 0; i < 8; i++)
            chr_set[i] = 8'(i);
        mirror_h = 1'b0;
        irq_reload = 8'h00;
        irq_count = 8'h00;
        reload_armed = 1'b0;
        reload_bonus = 1'b0;
        count_cpu = 1'b0;
        irq_on = 1'b0;
        pre_div = 2'd0;
        fire_wait = 2'd0;
        a12_quiet = 5'd0;
        irq_out = 1'b0;
        nt_cfg = 1'b0;

        repeat (5) @(posedge aclk);
        aresetn <= 1'b1;
        set_nametable_cfg(1'b0);

        add_cycle(OP_CYCLE, 16'h0000, 8'h00, 1'b0, 14'h0000);
        add_cycle(OP_CYCLE, 16'hFFFF, 8'hFF, 1'b1, 14'h3FFF);
        // swap both, 1k chr, index 0xF
        add_cycle(OP_WRITE, 16'h8000, 8'hFF, 1'b0, 14'h1C00);
        add_cycle(OP_WRITE, 16'h8001, 8'hFF, 1'b0, 14'h0400);
        // unused bank indexes, data must be dropped
        add_cycle(OP_WRITE, 16'h8000, 8'h0A, 1'b0, 14'h2C00);
        add_cycle(OP_WRITE, 16'h8001, 8'h5A, 1'b0, 14'h0800);
        add_cycle(OP_WRITE, 16'h8000, 8'h0E, 1'b0, 14'h1000);
        add_cycle(OP_WRITE, 16'h8001, 8'hA5, 1'b0, 14'h1400);
        // prg swap, 2k chr, first prg register
        add_cycle(OP_WRITE, 16'h8000, 8'h46, 1'b0, 14'h0C00);
        add_cycle(OP_WRITE, 16'h8001, 8'h81, 1'b0, 14'h0400);
        // unmapped write addresses
        add_cycle(OP_WRITE, 16'h9002, 8'h33, 1'b0, 14'h0000);
        add_cycle(OP_WRITE, 16'h7001, 8'h44, 1'b0, 14'h2400);
        add_cycle(OP_WRITE, 16'hA000, 8'h01, 1'b0, 14'h2800);
        add_cycle(OP_WRITE, 16'hC000, 8'h00, 1'b0, 14'h3000);
        add_cycle(OP_WRITE, 16'hE001, 8'h00, 1'b0, 14'h0000);
        add_cycle(OP_WRITE, 16'hC001, 8'h01, 1'b0, 14'h0000);
        repeat (6) add_cycle(OP_CYCLE, 16'hC000, 8'h00, 1'b0, 14'h2000);
        // latch 0xff plus the extra clock wraps to zero
        add_cycle(OP_WRITE, 16'hC000, 8'hFF, 1'b0, 14'h2400);
        add_cycle(OP_WRITE, 16'hC001, 8'h00, 1'b1, 14'h3C00);
        add_cycle(OP_CYCLE, 16'hE000, 8'h00, 1'b0, 14'h1800);
        add_cycle(OP_CYCLE, 16'h8000, 8'h00, 1'b1, 14'h2000);
        add_cycle(OP_WRITE, 16'hE000, 8'h00, 1'b0, 14'h0000);
        wait_drained();

        for (int phase = 0; phase < 4; phase++) begin
            set_nametable_cfg(phase[0] ? 1'b0 : 1'b1);
            repeat (PHASE_ITEMS) cycle_q.push_back(random_cycle());
            wait_drained();
        end

        repeat (10) @(posedge aclk);
        if (mismatches == 0 && expect_q.size() == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

`default_nettype wire

// ===== bank_mapper_with_scanline_irq_unit.f =====
hw/rtl/bmsi_pkg.sv
hw/rtl/bmsi_regs.sv
hw/rtl/bmsi_irq.sv
hw/rtl/bmsi_xlate.sv
hw/rtl/bank_mapper_with_scanline_irq_unit.sv
hw/rtl/bmsi_checker.sv
tb/sv/bank_mapper_with_scanline_irq_unit_test.sv
